// ===== src/sto_pkg.sv =====
// Package for the sorted timer queue: sizes, codes and the item records
// shared by the front end, back end, result FIFO and top level.
// No dependencies.
`default_nettype none
package sto_pkg;
	localparam int TIMER_SLOTS = 16;
	localparam int MAX_FIRE = 16;
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
	localparam int NFIRE_W = $clog2(MAX_FIRE + 1);
	localparam int TIME_W = 48;
	localparam int PER_W = 32;
	localparam int ID_W = 8;
	localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TIMER_SLOTS);
	localparam logic [NFIRE_W-1:0] FIRE_LIM = NFIRE_W'(MAX_FIRE);

	localparam logic FUNC_SCHED = 1'b0;
	localparam logic KIND_EXPIRY = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	typedef enum logic [1:0] {ST_OK = 2'd0, ST_NO_CB = 2'd1, ST_FULL = 2'd2} status_t;
	typedef enum logic [1:0] {OP_NONE, OP_INS, OP_POP} tbl_op_t;
	typedef enum logic [1:0] {BK_IDLE, BK_CHECK, BK_REINS} bk_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic ins;
		logic [TIME_W-1:0] dl;
		logic [PER_W-1:0] per;
		logic [ID_W-1:0] cb;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic [ID_W-1:0] fired_id;
		logic [TIME_W-1:0] next_deadline;
		status_t status;
		logic last;
	} res_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [PER_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {{(TIME_W + 1 - PER_W){1'b0}}, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== src/sto_front.sv =====
// Front end: accepts requests, classifies them and computes the new deadline,
// then holds them in a two-entry command queue. Depends on sto_pkg.
`default_nettype none
module sto_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic func,
	input wire logic [47:0] now,
	input wire logic [7:0] callback_id,
	input wire logic [31:0] interval,
	input wire logic one_shot,
	output logic cmd_valid,
	output sto_pkg::cmd_t cmd,
	input wire logic cmd_pop
);
	sto_pkg::cmd_t q_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	sto_pkg::cmd_t c;
	logic wr;

	always_comb begin
		c.now = now;
		c.ins = (func == sto_pkg::FUNC_SCHED) && (callback_id != '0);
		c.dl = sto_pkg::sat_add(now, interval);
		c.per = one_shot ? '0 : interval;
		c.cb = callback_id;
		c.status = ((func == sto_pkg::FUNC_SCHED) && (callback_id == '0)) ?
			sto_pkg::ST_NO_CB : sto_pkg::ST_OK;
	end

	assign full = cnt_q[1];
	assign wr = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) q_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (cmd_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, cmd_pop};
		end
	end
endmodule
`default_nettype wire

// ===== src/sto_rfifo.sv =====
// Two-entry result FIFO between the back end and the result port.
// Depends on sto_pkg.
`default_nettype none
module sto_rfifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr,
	input sto_pkg::res_t wdata,
	output logic rf_full,
	output logic empty,
	input wire logic pop,
	output sto_pkg::res_t rdata
);
	sto_pkg::res_t q_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic rd;

	assign rf_full = cnt_q[1];
	assign empty = cnt_q == 2'd0;
	assign rd = pop && !empty;
	assign rdata = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) q_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule
`default_nettype wire

// ===== src/sto_back.sv =====
// Back end: sorted timer table as a row of shift cells plus the sequencer
// that inserts, fires due timers, reloads periodic ones and closes each run.
// Depends on sto_pkg.
`default_nettype none
module sto_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [31:0] max_tick,
	input wire logic cmd_valid,
	input sto_pkg::cmd_t cmd,
	output logic cmd_pop,
	input wire logic rf_full,
	output logic rf_wr,
	output sto_pkg::res_t rf_data,
	output logic [sto_pkg::CNT_W-1:0] count
);
	localparam int N = sto_pkg::TIMER_SLOTS;

	logic [sto_pkg::TIME_W-1:0] dl_q [N];
	logic [sto_pkg::PER_W-1:0] per_q [N];
	logic [sto_pkg::ID_W-1:0] cb_q [N];
	logic [sto_pkg::CNT_W-1:0] count_q;

	sto_pkg::bk_state_t state_q, state_d;
	logic [sto_pkg::TIME_W-1:0] now_q, re_dl_q;
	logic [sto_pkg::PER_W-1:0] re_per_q;
	logic [sto_pkg::ID_W-1:0] re_cb_q;
	sto_pkg::status_t status_q;
	logic [sto_pkg::NFIRE_W-1:0] n_q;

	sto_pkg::tbl_op_t op;
	logic [sto_pkg::TIME_W-1:0] new_dl;
	logic [sto_pkg::PER_W-1:0] new_per;
	logic [sto_pkg::ID_W-1:0] new_cb;
	logic [N-1:0] lt;
	logic tbl_full, due, fire;

	assign count = count_q;
	assign tbl_full = count_q == sto_pkg::SLOTS_CNT;
	assign due = (count_q != '0) && (dl_q[0] <= now_q) && (n_q < sto_pkg::FIRE_LIM);
	assign fire = (state_q == sto_pkg::BK_CHECK) && due && !rf_full;

	// lt is a prefix mask since the table stays sorted
	for (genvar i = 0; i < N; i++) begin : g_cell
		assign lt[i] = (sto_pkg::CNT_W'(i) < count_q) && (dl_q[i] < new_dl);
		always_ff @(posedge clk) begin
			case (op)
				sto_pkg::OP_INS: begin
					if (!lt[i]) begin
						if (i == 0 || lt[(i == 0) ? 0 : i - 1]) begin
							dl_q[i] <= new_dl;
							per_q[i] <= new_per;
							cb_q[i] <= new_cb;
						end else begin
							dl_q[i] <= dl_q[(i == 0) ? 0 : i - 1];
							per_q[i] <= per_q[(i == 0) ? 0 : i - 1];
							cb_q[i] <= cb_q[(i == 0) ? 0 : i - 1];
						end
					end
				end
				sto_pkg::OP_POP: begin
					if (i < N - 1) begin
						dl_q[i] <= dl_q[(i < N - 1) ? i + 1 : i];
						per_q[i] <= per_q[(i < N - 1) ? i + 1 : i];
						cb_q[i] <= cb_q[(i < N - 1) ? i + 1 : i];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sto_pkg::BK_IDLE: if (cmd_valid) state_d = sto_pkg::BK_CHECK;
			sto_pkg::BK_CHECK: begin
				if (!rf_full) begin
					if (due) state_d = (per_q[0] != '0) ? sto_pkg::BK_REINS : sto_pkg::BK_CHECK;
					else state_d = sto_pkg::BK_IDLE;
				end
			end
			sto_pkg::BK_REINS: state_d = sto_pkg::BK_CHECK;
			default: state_d = sto_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		op = sto_pkg::OP_NONE;
		new_dl = cmd.dl;
		new_per = cmd.per;
		new_cb = cmd.cb;
		rf_wr = 1'b0;
		rf_data.kind = sto_pkg::KIND_EXPIRY;
		rf_data.fired_id = cb_q[0];
		rf_data.next_deadline = '0;
		rf_data.status = sto_pkg::ST_OK;
		rf_data.last = 1'b0;
		case (state_q)
			sto_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.ins && !tbl_full) op = sto_pkg::OP_INS;
				end
			end
			sto_pkg::BK_CHECK: begin
				if (!rf_full) begin
					rf_wr = 1'b1;
					if (due) begin
						op = sto_pkg::OP_POP;
					end else begin
						rf_data.kind = sto_pkg::KIND_FINAL;
						rf_data.fired_id = '0;
						rf_data.next_deadline = (count_q != '0) ? dl_q[0] :
							sto_pkg::sat_add(now_q, max_tick);
						rf_data.status = status_q;
						rf_data.last = 1'b1;
					end
				end
			end
			sto_pkg::BK_REINS: begin
				op = sto_pkg::OP_INS;
				new_dl = re_dl_q;
				new_per = re_per_q;
				new_cb = re_cb_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			now_q <= cmd.now;
			status_q <= (cmd.ins && tbl_full) ? sto_pkg::ST_FULL : cmd.status;
		end
		if (fire) begin
			re_dl_q <= sto_pkg::sat_add(dl_q[0], per_q[0]);
			re_per_q <= per_q[0];
			re_cb_q <= cb_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sto_pkg::BK_IDLE;
			count_q <= '0;
			n_q <= '0;
		end else begin
			state_q <= state_d;
			if (op == sto_pkg::OP_INS) count_q <= count_q + 1'b1;
			else if (op == sto_pkg::OP_POP) count_q <= count_q - 1'b1;
			if (cmd_pop) n_q <= '0;
			else if (fire) n_q <= n_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== src/sorted_timer_queue_unit.sv =====
// Sorted timer queue top level: front end, back end and result FIFO.
// Depends on sto_pkg, sto_front, sto_back, sto_rfifo.
//
// Usage:
//  Input queue: drive func/now/callback_id/interval/one_shot and raise push;
//  the transfer happens on a clock edge with push high and full low.
//  Result queue: while empty is low the oldest result sits on the output
//  ports; pop high transfers it. Each item yields zero or more expiry
//  results (kind 0) followed by one final result (kind 1, last 1) carrying
//  the next deadline and the request status.
//  Idle, the back end takes an item (with its insert); then come one expiry
//  per due timer, each periodic one followed by a reload, and the final
//  result; its shared table port (one insert or head removal per cycle)
//  orders these steps. A two-entry command queue lets the front keep
//  taking items meanwhile. max_tick is written through cfg_we/cfg_data,
//  by the user only while the block is idle; the block does not enforce
//  this. Reset empties the table and both queues and sets max_tick to
//  1000. A stalled receiver fills the result FIFO and the back end waits.
`default_nettype none
module sorted_timer_queue_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic func,
	input wire logic [47:0] now,
	input wire logic [7:0] callback_id,
	input wire logic [31:0] interval,
	input wire logic one_shot,
	output logic empty,
	input wire logic pop,
	output logic kind,
	output logic [7:0] fired_id,
	output logic [47:0] next_deadline,
	output logic [1:0] status,
	output logic last,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_data
);
	logic [31:0] max_tick_q;
	logic cmd_valid, cmd_pop, rf_full, rf_wr;
	sto_pkg::cmd_t cmd;
	sto_pkg::res_t rf_data, rdata;
	logic [sto_pkg::CNT_W-1:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_tick_q <= 32'd1000;
		else if (cfg_we) max_tick_q <= cfg_data;
	end

	sto_front u_front (
		.clk, .arst_n, .push, .full, .func, .now, .callback_id, .interval,
		.one_shot, .cmd_valid, .cmd, .cmd_pop
	);

	sto_back u_back (
		.clk, .arst_n, .max_tick(max_tick_q), .cmd_valid, .cmd, .cmd_pop,
		.rf_full, .rf_wr, .rf_data, .count
	);

	sto_rfifo u_rfifo (
		.clk, .arst_n, .wr(rf_wr), .wdata(rf_data), .rf_full, .empty, .pop,
		.rdata
	);

	assign kind = rdata.kind;
	assign fired_id = rdata.fired_id;
	assign next_deadline = rdata.next_deadline;
	assign status = rdata.status;
	assign last = rdata.last;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= sto_pkg::SLOTS_CNT) else $error("timer count overflow");
	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kind == last)) else $error("last not on final result");
	a_expiry_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !kind) |-> (next_deadline == '0 && status == '0))
		else $error("expiry carries status fields");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr |-> !rf_full) else $error("result FIFO overrun");
endmodule
`default_nettype wire

// ===== tb/sorted_timer_queue_unit_test.sv =====
// Self-checking testbench for the sorted timer queue unit.
// Depends on sto_pkg and sorted_timer_queue_unit; predicts the expiry and
// final results of each item with its own copy of the timer table.
`default_nettype none
module sorted_timer_queue_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic FUNC_TICK = 1'b1;
	localparam logic [sto_pkg::TIME_W-1:0] TIME_MAX = {sto_pkg::TIME_W{1'b1}};

	typedef struct packed {
		logic func;
		logic [sto_pkg::TIME_W-1:0] now;
		logic [sto_pkg::ID_W-1:0] cb;
		logic [sto_pkg::PER_W-1:0] interval;
		logic one_shot;
	} req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic func = 1'b0;
	logic [47:0] now = '0;
	logic [7:0] callback_id = '0;
	logic [31:0] interval = '0;
	logic one_shot = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic kind;
	logic [7:0] fired_id;
	logic [47:0] next_deadline;
	logic [1:0] status;
	logic last;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_data = '0;

	sorted_timer_queue_unit DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.now(now), .callback_id(callback_id), .interval(interval),
		.one_shot(one_shot), .empty(empty), .pop(pop), .kind(kind),
		.fired_id(fired_id), .next_deadline(next_deadline), .status(status),
		.last(last), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// timer table copy
	logic [sto_pkg::TIME_W-1:0] tbl_dl[sto_pkg::TIMER_SLOTS];
	logic [sto_pkg::PER_W-1:0] tbl_per[sto_pkg::TIMER_SLOTS];
	logic [sto_pkg::ID_W-1:0] tbl_cb[sto_pkg::TIMER_SLOTS];
	int tbl_cnt = 0;
	logic [31:0] idle_tick = 32'd1000;

	req_t pending_reqs[$];
	sto_pkg::res_t expected_res[$];
	int n_items = 0, n_results = 0, n_fires = 0, n_mismatch = 0;
	bit hold_req = 1'b0;
	bit hold_rx = 1'b0;
	int quiet_cycles = 0;

	function automatic logic [sto_pkg::TIME_W-1:0] add_clamped(
			logic [sto_pkg::TIME_W-1:0] a, logic [sto_pkg::PER_W-1:0] b);
		logic [sto_pkg::TIME_W:0] s;
		s = {1'b0, a} + (sto_pkg::TIME_W + 1)'(b);
		return s[sto_pkg::TIME_W] ? TIME_MAX : s[sto_pkg::TIME_W-1:0];
	endfunction

	function automatic void tbl_insert(logic [sto_pkg::TIME_W-1:0] dl,
			logic [sto_pkg::PER_W-1:0] per, logic [sto_pkg::ID_W-1:0] cb);
		int pos;
		pos = 0;
		while (pos < tbl_cnt && tbl_dl[pos] < dl)
			pos++;
		for (int i = tbl_cnt; i > pos; i--) begin
			tbl_dl[i] = tbl_dl[i-1];
			tbl_per[i] = tbl_per[i-1];
			tbl_cb[i] = tbl_cb[i-1];
		end
		tbl_dl[pos] = dl;
		tbl_per[pos] = per;
		tbl_cb[pos] = cb;
		tbl_cnt++;
	endfunction

	function automatic void predict_timers(req_t r);
		sto_pkg::status_t st;
		int nf;
		logic [sto_pkg::TIME_W-1:0] dl;
		logic [sto_pkg::PER_W-1:0] per;
		logic [sto_pkg::ID_W-1:0] id;
		sto_pkg::res_t e;
		st = sto_pkg::ST_OK;
		nf = 0;
		if (r.func == sto_pkg::FUNC_SCHED) begin
			if (r.cb == '0)
				st = sto_pkg::ST_NO_CB;
			else if (tbl_cnt >= sto_pkg::TIMER_SLOTS)
				st = sto_pkg::ST_FULL;
			else
				tbl_insert(add_clamped(r.now, r.interval),
					r.one_shot ? '0 : r.interval, r.cb);
		end
		while (nf < sto_pkg::MAX_FIRE && tbl_cnt > 0 && tbl_dl[0] <= r.now) begin
			dl = tbl_dl[0];
			per = tbl_per[0];
			id = tbl_cb[0];
			e = '0;
			e.kind = sto_pkg::KIND_EXPIRY;
			e.fired_id = id;
			e.status = sto_pkg::ST_OK;
			expected_res.push_back(e);
			nf++;
			n_fires++;
			for (int i = 1; i < tbl_cnt; i++) begin
				tbl_dl[i-1] = tbl_dl[i];
				tbl_per[i-1] = tbl_per[i];
				tbl_cb[i-1] = tbl_cb[i];
			end
			tbl_cnt--;
			if (per != '0)
				tbl_insert(add_clamped(dl, per), per, id);
		end
		e = '0;
		e.kind = sto_pkg::KIND_FINAL;
		e.next_deadline = tbl_cnt > 0 ? tbl_dl[0] : add_clamped(r.now, idle_tick);
		e.status = st;
		e.last = 1'b1;
		expected_res.push_back(e);
	endfunction

	// driver
	int tx_wait = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_timers('{func, now, callback_id, interval, one_shot});
				n_items++;
				tx_wait <= $urandom_range(0, 15) * ($urandom_range(0, 3) == 0);
				if (pending_reqs.size() > 0 && $urandom_range(0, 15) == 0) begin
					push <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					{func, now, callback_id, interval, one_shot} <= pending_reqs.pop_front();
				end else begin
					push <= 1'b0;
				end
			end else if (!push) begin
				if (tx_wait > 0)
					tx_wait <= tx_wait - 1;
				else if (pending_reqs.size() > 0) begin
					{func, now, callback_id, interval, one_shot} <= pending_reqs.pop_front();
					push <= 1'b1;
				end
			end
		end
	end

	// monitor
	int rx_wait = 0;
	always @(posedge clk) begin
		sto_pkg::res_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				n_results++;
				if (expected_res.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("unexpected result kind=%0d id=%0d", kind, fired_id);
				end else begin
					e = expected_res.pop_front();
					if (kind !== e.kind || fired_id !== e.fired_id ||
							next_deadline !== e.next_deadline ||
							status !== e.status || last !== e.last) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display({"mismatch: exp k%0d id%0d dl%0h st%0d l%0d, ",
								"got k%0d id%0d dl%0h st%0d l%0d"},
								e.kind, e.fired_id, e.next_deadline, e.status, e.last,
								kind, fired_id, next_deadline, status, last);
					end
				end
			end
			if (hold_rx) begin
				pop <= 1'b0;
			end else if (pop && !empty) begin
				rx_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
				pop <= ($urandom_range(0, 3) != 0);
			end else if (rx_wait > 0) begin
				rx_wait <= rx_wait - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk) begin
		if (hold_req && quiet_cycles < 400) begin
			hold_rx <= 1'b1;
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			hold_rx <= 1'b0;
		end
	end

	function automatic req_t mk_req(logic f, logic [sto_pkg::TIME_W-1:0] t,
			logic [sto_pkg::ID_W-1:0] cb, logic [sto_pkg::PER_W-1:0] iv, logic os);
		req_t r;
		r.func = f;
		r.now = t;
		r.cb = cb;
		r.interval = iv;
		r.one_shot = os;
		return r;
	endfunction

	task automatic drain();
		int guard;
		guard = 0;
		while ((pending_reqs.size() > 0 || push || expected_res.size() > 0) && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic set_idle_tick(logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		idle_tick = v;
	endtask

	// time advances in small steps; timers mostly use short intervals
	task automatic random_phase(int cnt, ref logic [sto_pkg::TIME_W-1:0] clock_ms);
		logic [31:0] iv;
		for (int i = 0; i < cnt; i++) begin
			clock_ms = add_clamped(clock_ms, $urandom_range(0, 40));
			case ($urandom_range(0, 9))
				0: iv = $urandom();
				1: iv = 0;
				default: iv = $urandom_range(1, 120);
			endcase
			if ($urandom_range(0, 2) == 0)
				pending_reqs.push_back(mk_req(FUNC_TICK, clock_ms, 8'($urandom()),
					$urandom(), 1'($urandom())));
			else
				pending_reqs.push_back(mk_req(sto_pkg::FUNC_SCHED, clock_ms,
					($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
					iv, 1'($urandom_range(0, 2) == 0)));
		end
	endtask

	logic [sto_pkg::TIME_W-1:0] t_ms;

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: missing callback, zero interval, fill the table, overflow,
		// fire limit, zero period, idle deadline at reset max_tick
		pending_reqs.push_back(mk_req(sto_pkg::FUNC_SCHED, 48'd100, 8'd0, 32'd5, 1'b1));
		pending_reqs.push_back(mk_req(FUNC_TICK, 48'd0, 8'hFF, 32'hFFFF_FFFF, 1'b1));
		pending_reqs.push_back(mk_req(sto_pkg::FUNC_SCHED, 48'd100, 8'd7, 32'd0, 1'b0));
		for (int i = 0; i < 17; i++)
			pending_reqs.push_back(mk_req(sto_pkg::FUNC_SCHED, 48'd200, 8'(i + 1),
				32'(i % 3 + 1), 1'(i % 2)));
		pending_reqs.push_back(mk_req(FUNC_TICK, 48'd300, 8'd0, 32'd0, 1'b0));
		pending_reqs.push_back(mk_req(FUNC_TICK, 48'd301, 8'd0, 32'd0, 1'b0));
		pending_reqs.push_back(mk_req(sto_pkg::FUNC_SCHED, TIME_MAX - 48'd3, 8'hFF,
			32'hFFFF_FFFF, 1'b0));
		pending_reqs.push_back(mk_req(FUNC_TICK, TIME_MAX, 8'd0, 32'd0, 1'b0));
		drain();

		set_idle_tick(32'd1);
		t_ms = 48'd1000;
		random_phase(120, t_ms);
		drain();

		set_idle_tick(32'hFFFF_FFFF);
		hold_req = 1'b1;
		random_phase(130, t_ms);
		pending_reqs.push_back(mk_req(FUNC_TICK, TIME_MAX, 8'hAA, 32'h5555_5555, 1'b0));
		drain();

		set_idle_tick(32'($urandom_range(2, 5000)));
		t_ms = 48'($urandom()) << 16;
		random_phase(110, t_ms);
		drain();

		$display("covered %0d items, %0d results, %0d expiries over four max_tick settings",
			n_items, n_results, n_fires);
		if (n_mismatch == 0 && expected_res.size() == 0)
			$display("sorted_timer_queue_unit_test: done, clean");
		else
			$display("sorted_timer_queue_unit_test: done, errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("sorted_timer_queue_unit_test: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sorted_timer_queue_unit.f =====
src/sto_pkg.sv
src/sto_front.sv
src/sto_rfifo.sv
src/sto_back.sv
src/sorted_timer_queue_unit.sv
tb/sorted_timer_queue_unit_test.sv
